>>> rtl/core/arw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arw_pkg: shared types and constants of the ARQ receive reorder window
// Command and result records, status and class codes, bus widths.
// ----------------------------------------------------------------------------
package arw_pkg;

    localparam int DEF_WINDOW_SLOTS = 4;
    localparam int DEF_TAG_BITS     = 8;
    localparam logic [15:0] RESET_LINK_TIMEOUT = 16'd3000;

    localparam int SEQ_W        = 32;
    localparam int SESS_W       = 32;
    localparam int TAG_IN_W     = 8;
    localparam int TIMEOUT_W    = 16;
    localparam int BITMAP_BITS  = 4;
    localparam int BITMAP_IDX_W = $clog2(BITMAP_BITS);

    // input queue between front and back; depth must be a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 5;
    localparam int M_FIELD_W = 81;
    localparam int M_TDATA_W = 88;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

    typedef enum logic [1:0] {
        ACT_FRAME = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_FAIL  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        CLS_DATA      = 2'd0,
        CLS_ACK       = 2'd1,
        CLS_HEARTBEAT = 2'd2,
        CLS_HELLO     = 2'd3
    } t_class;

    typedef enum logic [1:0] {
        K_FRAME = 2'd0,
        K_TICK  = 2'd1,
        K_FAIL  = 2'd2,
        K_BAD   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_STORED      = 3'd0,
        ST_DUPLICATE   = 3'd1,
        ST_BEYOND      = 3'd2,
        ST_WRONG_SESS  = 3'd3,
        ST_BAD_FRAME   = 3'd4,
        ST_CONTROL     = 3'd5,
        ST_TICK        = 3'd6,
        ST_LINK_DOWN   = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_EXEC   = 2'd1,
        S_DRAIN  = 2'd2,
        S_STATUS = 2'd3
    } t_state;

    typedef struct packed {
        t_kind               kind;
        logic                ctrl;      // control frame: non-data class or sequence zero
        logic                ctrl_ack;  // control frame wants an ack
        logic                is_hello;
        logic [SESS_W-1:0]   session;
        logic [SEQ_W-1:0]    seq;
        logic [TAG_IN_W-1:0] tag;
    } t_cmd;

    typedef struct packed {
        logic                   is_delivery;
        logic [SEQ_W-1:0]       seq;
        logic [TAG_IN_W-1:0]    tag;
        t_status                status;
        logic                   send_ack;
        logic [SEQ_W-1:0]       ack_upto;
        logic [BITMAP_BITS-1:0] ack_mask;
        logic                   link_up;
        logic                   last;
    } t_result;

endpackage

>>> rtl/core/arw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arw_front: input side of the reorder window
// Takes event transactions and classifies them into queue commands.
// ----------------------------------------------------------------------------
module arw_front (
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [arw_pkg::S_TDATA_W-1:0] i_tdata,
    input  logic [arw_pkg::S_TUSER_W-1:0] i_tuser,
    input  logic                         i_q_full,
    output logic                         o_push,
    output arw_pkg::t_cmd                o_cmd
);
    import arw_pkg::*;

    logic [1:0]          action;
    logic                frame_ok;
    logic [1:0]          frame_class;
    logic [SEQ_W-1:0]    seq;

    assign action      = i_tuser[1:0];
    assign frame_ok    = i_tuser[2];
    assign frame_class = i_tuser[4:3];
    assign seq         = i_tdata[63:32];

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_cmd.session  = i_tdata[31:0];
        o_cmd.seq      = seq;
        o_cmd.tag      = i_tdata[71:64];
        o_cmd.ctrl     = (frame_class != CLS_DATA) || (seq == '0);
        o_cmd.ctrl_ack = (frame_class != CLS_ACK);
        o_cmd.is_hello = (frame_class == CLS_HELLO);
        unique case (action)
            ACT_FRAME: o_cmd.kind = frame_ok ? K_FRAME : K_BAD;
            ACT_TICK:  o_cmd.kind = K_TICK;
            ACT_FAIL:  o_cmd.kind = K_FAIL;
            default:   o_cmd.kind = K_BAD;
        endcase
    end

endmodule

>>> rtl/core/arw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arw_queue: command queue between front and back
// Small register FIFO so either side can stall on its own.
// ----------------------------------------------------------------------------
module arw_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  arw_pkg::t_cmd i_wdata,
    output logic          o_full,
    input  logic          i_pop,
    output arw_pkg::t_cmd o_rdata,
    output logic          o_empty
);
    import arw_pkg::*;

    t_cmd                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count, n_count;

    assign o_full  = (r_count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

>>> rtl/core/arw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arw_back: window state and result sequencer
// Runs a command, drains in-order slots one per unstalled cycle, emits status.
// ----------------------------------------------------------------------------
module arw_back #(
    parameter int WINDOW_SLOTS = arw_pkg::DEF_WINDOW_SLOTS,
    parameter int TAG_BITS     = arw_pkg::DEF_TAG_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [arw_pkg::TIMEOUT_W-1:0]  i_cfg_wdata,
    input  logic                           i_q_empty,
    input  arw_pkg::t_cmd                  i_cmd,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output arw_pkg::t_result               o_out
);
    import arw_pkg::*;

    localparam int SLOT_IDX_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

    t_state                 r_state, n_state;
    logic [WINDOW_SLOTS-1:0] r_slot_valid, n_slot_valid;
    logic [SEQ_W-1:0]       r_slot_seq [WINDOW_SLOTS];
    logic [TAG_BITS-1:0]    r_slot_tag [WINDOW_SLOTS];
    logic [SEQ_W-1:0]       r_base, n_base;
    logic [SESS_W-1:0]      r_peer, n_peer;
    logic                   r_link, n_link;
    logic [SEQ_W-1:0]       r_now, n_now;
    logic [SEQ_W-1:0]       r_last_rx, n_last_rx;
    logic [TIMEOUT_W-1:0]   r_timeout, n_timeout;
    t_cmd                   r_cmd;
    t_status                r_status, n_status;
    logic                   r_ack, n_ack;
    logic                   r_out_valid, n_out_valid;
    t_result                r_out, n_out;

    logic                   out_free;
    logic                   ld_deliv;
    logic                   ld_status;
    logic                   store;
    logic                   drain;
    logic [SEQ_W-1:0]       tick_now;
    logic                   accepted;
    logic                   hello_new;
    logic                   hit_found, free_found, drn_found;
    logic [SLOT_IDX_W-1:0]  free_idx, drn_idx;
    logic [SEQ_W-1:0]       want_seq;
    logic [SEQ_W-1:0]       bm_dist [WINDOW_SLOTS];
    logic [BITMAP_BITS-1:0] bitmap;

    assign out_free  = !r_out_valid || i_out_ready;
    assign tick_now  = r_now + 32'd1;
    assign want_seq  = r_base + 32'd1;
    assign hello_new = (r_peer != r_cmd.session) && r_cmd.is_hello
                       && ((r_peer == '0) || !r_link);
    assign accepted  = (r_peer == r_cmd.session) || hello_new;

    // slot searches: lowest index wins
    always_comb begin
        hit_found  = 1'b0;
        free_found = 1'b0;
        drn_found  = 1'b0;
        free_idx   = '0;
        drn_idx    = '0;
        for (int i = WINDOW_SLOTS - 1; i >= 0; i--) begin
            if (r_slot_valid[i] && (r_slot_seq[i] == r_cmd.seq)) begin
                hit_found = 1'b1;
            end
            if (!r_slot_valid[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_IDX_W'(i);
            end
            if (r_slot_valid[i] && (r_slot_seq[i] == want_seq)) begin
                drn_found = 1'b1;
                drn_idx   = SLOT_IDX_W'(i);
            end
        end
    end

    always_comb begin
        bitmap = '0;
        for (int i = 0; i < WINDOW_SLOTS; i++) begin
            bm_dist[i] = r_slot_seq[i] - r_base;
            if (r_slot_valid[i] && (r_slot_seq[i] > r_base)
                && (bm_dist[i] <= 32'(BITMAP_BITS))) begin
                bitmap[BITMAP_IDX_W'(bm_dist[i] - 32'd1)] = 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (!i_q_empty) n_state = S_EXEC;
            S_EXEC:   n_state = drain ? S_DRAIN : S_STATUS;
            S_DRAIN:  if (!drn_found) n_state = S_STATUS;
            S_STATUS: if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_pop     = 1'b0;
        ld_deliv  = 1'b0;
        ld_status = 1'b0;
        unique case (r_state)
            S_IDLE:   o_pop     = !i_q_empty;
            S_EXEC:   ;
            S_DRAIN:  ld_deliv  = drn_found && out_free;
            S_STATUS: ld_status = out_free;
            default:  ;
        endcase
    end

    // command execution and window updates
    always_comb begin
        n_slot_valid = r_slot_valid;
        n_base       = r_base;
        n_peer       = r_peer;
        n_link       = r_link;
        n_now        = r_now;
        n_last_rx    = r_last_rx;
        n_status     = r_status;
        n_ack        = r_ack;
        store        = 1'b0;
        drain        = 1'b0;
        if (r_state == S_EXEC) begin
            n_status = ST_BAD_FRAME;
            n_ack    = 1'b0;
            unique case (r_cmd.kind)
                K_TICK: begin
                    n_now    = tick_now;
                    n_status = ST_TICK;
                    if (r_link && ((tick_now - r_last_rx) > 32'(r_timeout))) begin
                        n_link   = 1'b0;
                        n_status = ST_LINK_DOWN;
                    end
                end
                K_FAIL: begin
                    n_link   = 1'b0;
                    n_status = ST_LINK_DOWN;
                end
                K_FRAME: begin
                    if (!accepted) begin
                        n_status = ST_WRONG_SESS;
                    end else begin
                        if (hello_new) begin
                            n_slot_valid = '0;
                            n_base       = '0;
                            n_peer       = r_cmd.session;
                        end
                        n_last_rx = r_now;
                        n_link    = 1'b1;
                        if (r_cmd.ctrl) begin
                            n_status = ST_CONTROL;
                            n_ack    = r_cmd.ctrl_ack;
                        end else if (r_cmd.seq <= r_base) begin
                            n_status = ST_DUPLICATE;
                            n_ack    = 1'b1;
                        end else if ((r_cmd.seq - r_base) > 32'(WINDOW_SLOTS)) begin
                            n_status = ST_BEYOND;
                            n_ack    = 1'b1;
                        end else if (hit_found) begin
                            n_status = ST_DUPLICATE;
                            n_ack    = 1'b1;
                            drain    = 1'b1;
                        end else if (free_found) begin
                            n_slot_valid[free_idx] = 1'b1;
                            store    = 1'b1;
                            n_status = ST_STORED;
                            n_ack    = 1'b1;
                            drain    = 1'b1;
                        end else begin
                            // inconsistent window: drop quietly
                            n_status = ST_BEYOND;
                        end
                    end
                end
                default: ;
            endcase
        end else if (ld_deliv) begin
            n_base                = r_slot_seq[drn_idx];
            n_slot_valid[drn_idx] = 1'b0;
        end
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (ld_deliv) begin
            n_out_valid      = 1'b1;
            n_out            = '0;
            n_out.is_delivery = 1'b1;
            n_out.seq        = r_slot_seq[drn_idx];
            n_out.tag        = TAG_IN_W'(r_slot_tag[drn_idx]);
            n_out.status     = ST_STORED;
        end else if (ld_status) begin
            n_out_valid      = 1'b1;
            n_out            = '0;
            n_out.status     = r_status;
            n_out.send_ack   = r_ack;
            n_out.ack_upto   = r_base;
            n_out.ack_mask   = bitmap;
            n_out.link_up    = r_link;
            n_out.last       = 1'b1;
        end
    end

    always_comb begin
        n_timeout = i_cfg_we ? i_cfg_wdata : r_timeout;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot_valid <= '0;
            r_base       <= '0;
            r_peer       <= '0;
            r_link       <= 1'b0;
            r_now        <= '0;
            r_last_rx    <= '0;
            r_timeout    <= RESET_LINK_TIMEOUT;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slot_valid <= n_slot_valid;
            r_base       <= n_base;
            r_peer       <= n_peer;
            r_link       <= n_link;
            r_now        <= n_now;
            r_last_rx    <= n_last_rx;
            r_timeout    <= n_timeout;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (store) begin
            r_slot_seq[free_idx] <= r_cmd.seq;
            r_slot_tag[free_idx] <= TAG_BITS'(r_cmd.tag);
        end
        r_status <= n_status;
        r_ack    <= n_ack;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a delivery never closes the event
    a_deliv_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.is_delivery) |-> !r_out.last)
        else $error("delivery item flagged as last");

    // each delivery advances the base by exactly one
    a_base_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_deliv |=> (r_base == $past(r_base) + 32'd1))
        else $error("delivery did not advance base by one");

    // a link failure always leaves the link down
    a_fail_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_cmd.kind == K_FAIL) |=> !r_link)
        else $error("link still up after link failure");

    // execution only follows a pop
    a_exec_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $past(o_pop))
        else $error("command executed without a queue pop");

endmodule

>>> rtl/core/arq_receive_reorder_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arq_receive_reorder_window: selective-repeat ARQ receive window
// Session tracking, link timeout and in-order delivery of buffered frames.
// ----------------------------------------------------------------------------
// Each event transaction (frame header, millisecond tick or link failure) goes
// through a two-entry command queue into a sequencer that owns the window.
// The sequencer takes the command in S_IDLE, executes it in S_EXEC and issues
// the status result in S_STATUS; a stored data frame, or a duplicate of a held
// one, first visits S_DRAIN for each in-order delivery and for a final search
// that finds no further slot, one delivery per cycle while the output is free.
// Results pass through an output register; the queue keeps taking events
// while a result waits. The user must write the link timeout in ms, through
// i_cfg_we/i_cfg_wdata only while the block is idle, which it does not check.
// ----------------------------------------------------------------------------
module arq_receive_reorder_window #(
    parameter int WINDOW_SLOTS = arw_pkg::DEF_WINDOW_SLOTS,
    parameter int TAG_BITS     = arw_pkg::DEF_TAG_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [arw_pkg::TIMEOUT_W-1:0]  i_cfg_wdata,   // link timeout, ms
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // sender_sess[31:0], sequence_req[63:32], frame_tag[71:64]
    input  logic [arw_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // action[1:0], frame_ok[2], frame_class[4:3]
    input  logic [arw_pkg::S_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // delivered_sequence[31:0], delivered_tag[39:32], status[42:40],
    // send_ack[43], ack_upto[75:44], ack_mask[79:76], link_up[80], zero pad
    output logic [arw_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    output logic                           o_m_axis_tuser,  // is_delivery
    output logic                           o_m_axis_tlast
);
    import arw_pkg::*;

    logic    q_full, q_empty, push, pop;
    t_cmd    f_cmd, q_cmd;
    t_result res;

    arw_front u_front (
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_tdata  (i_s_axis_tdata),
        .i_tuser  (i_s_axis_tuser),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (f_cmd)
    );

    arw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (f_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_rdata (q_cmd),
        .o_empty (q_empty)
    );

    arw_back #(
        .WINDOW_SLOTS (WINDOW_SLOTS),
        .TAG_BITS     (TAG_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_empty   (q_empty),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out       (res)
    );

    assign o_m_axis_tdata = {M_PAD_W'(0), res.link_up, res.ack_mask, res.ack_upto,
                             res.send_ack, res.status, res.tag, res.seq};
    assign o_m_axis_tuser = res.is_delivery;
    assign o_m_axis_tlast = res.last;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for arq_receive_reorder_window
// Drives frame headers, ticks and link failures with random source gaps and
// sink stalls. An in-bench window model predicts every delivery and status
// transaction, and each output transaction is compared field by field.
// ----------------------------------------------------------------------------
module testbench;

    import arw_pkg::*;

    localparam int          WINDOW      = DEF_WINDOW_SLOTS;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [TIMEOUT_W-1:0]  i_cfg_wdata;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [S_TDATA_W-1:0]  i_s_axis_tdata;
    logic [S_TUSER_W-1:0]  i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;
    logic                  o_m_axis_tuser;
    logic                  o_m_axis_tlast;

    arq_receive_reorder_window dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // window model state
    logic                 win_valid [WINDOW];
    logic [SEQ_W-1:0]     win_seq   [WINDOW];
    logic [TAG_IN_W-1:0]  win_tag   [WINDOW];
    logic [SEQ_W-1:0]     win_base;
    logic [SESS_W-1:0]    peer_id;
    logic                 link_alive;
    logic [31:0]          clock_ms;
    logic [31:0]          last_heard_ms;
    logic [TIMEOUT_W-1:0] timeout_ms;

    t_result outcome_q [$];
    int      fault_count;
    int      cycle_count;
    int      sink_hold;
    logic    idle_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("arq_receive_reorder_window verification failed");
        $finish;
    end

    // ---------------- window model ----------------

    function automatic logic [BITMAP_BITS-1:0] held_map();
        logic [31:0] map;
        logic [31:0] d;
        map = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if (win_valid[i] && win_seq[i] > win_base) begin
                d = win_seq[i] - win_base;
                if (d <= 32'd32) map |= 32'd1 << (d - 32'd1);
            end
        end
        return map[BITMAP_BITS-1:0];
    endfunction

    function automatic void queue_outcome(logic deliv, logic [SEQ_W-1:0] seq,
                                          logic [TAG_IN_W-1:0] tag, t_status st,
                                          logic ack);
        t_result r;
        r = '0;
        r.is_delivery = deliv;
        if (deliv) begin
            r.seq = seq;
            r.tag = tag;
        end else begin
            r.status     = st;
            r.send_ack   = ack;
            r.ack_upto   = win_base;
            r.ack_mask   = held_map();
            r.link_up    = link_alive;
            r.last       = 1'b1;
        end
        outcome_q.push_back(r);
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < WINDOW; i++) win_valid[i] = 1'b0;
        win_base = '0;
    endfunction

    function automatic void reset_window_model();
        clear_window();
        peer_id       = '0;
        link_alive    = 1'b0;
        clock_ms      = '0;
        last_heard_ms = '0;
        timeout_ms    = RESET_LINK_TIMEOUT;
    endfunction

    // applies one event to the model and queues the transactions it causes
    function automatic void advance_window(logic [1:0] act, logic ok,
                                           logic [SESS_W-1:0] sess, logic [1:0] cls,
                                           logic [SEQ_W-1:0] seq,
                                           logic [TAG_IN_W-1:0] tag);
        t_status st;
        logic    ack;
        logic    accepted;
        int      hit;
        int      free_slot;
        int      f;
        st  = ST_BAD_FRAME;
        ack = 1'b0;
        if (act == ACT_TICK) begin
            clock_ms = clock_ms + 32'd1;
            st = ST_TICK;
            if (link_alive && (clock_ms - last_heard_ms) > {16'd0, timeout_ms}) begin
                link_alive = 1'b0;
                st = ST_LINK_DOWN;
            end
        end else if (act == ACT_FAIL) begin
            link_alive = 1'b0;
            st = ST_LINK_DOWN;
        end else if (act == ACT_FRAME && ok) begin
            accepted = 1'b0;
            if (peer_id == sess) begin
                accepted = 1'b1;
            end else if (cls == CLS_HELLO && (peer_id == '0 || !link_alive)) begin
                clear_window();
                peer_id  = sess;
                accepted = 1'b1;
            end
            if (!accepted) begin
                st = ST_WRONG_SESS;
            end else begin
                last_heard_ms = clock_ms;
                link_alive    = 1'b1;
                if (cls != CLS_DATA || seq == '0) begin
                    st  = ST_CONTROL;
                    ack = (cls != CLS_ACK);
                end else if (seq <= win_base) begin
                    st  = ST_DUPLICATE;
                    ack = 1'b1;
                end else if (seq - win_base > 32'(WINDOW)) begin
                    st  = ST_BEYOND;
                    ack = 1'b1;
                end else begin
                    hit       = -1;
                    free_slot = -1;
                    for (int i = 0; i < WINDOW; i++) begin
                        if (hit < 0 && win_valid[i] && win_seq[i] == seq) hit = i;
                        if (free_slot < 0 && !win_valid[i]) free_slot = i;
                    end
                    if (hit >= 0) begin
                        st  = ST_DUPLICATE;
                        ack = 1'b1;
                    end else if (free_slot >= 0) begin
                        win_valid[free_slot] = 1'b1;
                        win_seq[free_slot]   = seq;
                        win_tag[free_slot]   = tag;
                        st  = ST_STORED;
                        ack = 1'b1;
                    end else begin
                        st  = ST_BEYOND;
                        ack = 1'b0;
                    end
                    if (st != ST_BEYOND) begin
                        // drain everything that is now in order
                        do begin
                            f = -1;
                            for (int i = 0; i < WINDOW; i++)
                                if (f < 0 && win_valid[i] && win_seq[i] == win_base + 32'd1)
                                    f = i;
                            if (f >= 0) begin
                                queue_outcome(1'b1, win_seq[f], win_tag[f], ST_STORED, 1'b0);
                                win_base     = win_seq[f];
                                win_valid[f] = 1'b0;
                            end
                        end while (f >= 0);
                    end
                end
            end
        end
        queue_outcome(1'b0, '0, '0, st, ack);
    endfunction

    // ---------------- result checking ----------------

    function automatic void note_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            fault_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result seen;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen.is_delivery = o_m_axis_tuser;
            seen.seq         = o_m_axis_tdata[31:0];
            seen.tag         = o_m_axis_tdata[39:32];
            seen.status      = t_status'(o_m_axis_tdata[42:40]);
            seen.send_ack    = o_m_axis_tdata[43];
            seen.ack_upto    = o_m_axis_tdata[75:44];
            seen.ack_mask    = o_m_axis_tdata[79:76];
            seen.link_up     = o_m_axis_tdata[80];
            seen.last        = o_m_axis_tlast;
            if (outcome_q.size() == 0) begin
                $display("%0t ns: unexpected transaction, expected none, got %h",
                         $time, seen);
                fault_count++;
            end else begin
                want = outcome_q.pop_front();
                note_field("is_delivery", 32'(want.is_delivery), 32'(seen.is_delivery));
                note_field("delivered_sequence", want.seq, seen.seq);
                note_field("delivered_tag", 32'(want.tag), 32'(seen.tag));
                note_field("status", 32'(want.status), 32'(seen.status));
                note_field("send_ack", 32'(want.send_ack), 32'(seen.send_ack));
                note_field("ack_upto", want.ack_upto, seen.ack_upto);
                note_field("ack_mask", 32'(want.ack_mask), 32'(seen.ack_mask));
                note_field("link_up", 32'(want.link_up), 32'(seen.link_up));
                note_field("last", 32'(want.last), 32'(seen.last));
            end
        end
    end

    // sink: mostly ready, short stalls, the odd long one
    always @(posedge i_clk) begin
        if (sink_hold > 0)
            sink_hold = sink_hold - 1;
        else if (idle_on && $urandom_range(0, 99) < 12)
            sink_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
        i_m_axis_tready <= (sink_hold == 0);
    end

    // ---------------- stimulus ----------------

    task automatic send_event(input logic [1:0] act, input logic ok,
                              input logic [SESS_W-1:0] sess, input logic [1:0] cls,
                              input logic [SEQ_W-1:0] seq, input logic [TAG_IN_W-1:0] tag);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {tag, seq, sess};
        i_s_axis_tuser  <= {cls, ok, act};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        advance_window(act, ok, sess, cls, seq, tag);
        gap = 0;
        if (idle_on) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: gap = 0;
                6, 7, 8:          gap = $urandom_range(1, 3);
                default:          gap = $urandom_range(8, 30);
            endcase
        end
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_frame(input logic [SESS_W-1:0] sess, input logic [1:0] cls,
                              input logic [SEQ_W-1:0] seq, input logic [TAG_IN_W-1:0] tag);
        send_event(ACT_FRAME, 1'b1, sess, cls, seq, tag);
    endtask

    // lower tvalid and let every outstanding transaction drain
    task automatic wait_quiet();
        i_s_axis_tvalid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_timeout(input logic [TIMEOUT_W-1:0] value);
        wait_quiet();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        timeout_ms = value;
    endtask

    task automatic test_window_basics();
        send_event(ACT_FRAME, 1'b0, '1, CLS_HELLO, '1, 8'hFF);   // bad frame
        send_event(ACT_UNUSED, 1'b1, '1, CLS_HELLO, '1, 8'hFF);  // unused action
        send_event(ACT_TICK, 1'b0, '0, CLS_DATA, '0, 8'h00);
        send_frame(32'hFFFF_FFFF, CLS_DATA, 32'd1, 8'h11);       // wrong session
        // session zero matches the reset peer
        send_frame('0, CLS_DATA, 32'd2, 8'h00);
        send_frame('0, CLS_DATA, 32'd3, 8'hFF);
        send_frame('0, CLS_DATA, 32'd4, 8'hA5);
        send_frame('0, CLS_DATA, 32'd3, 8'h33);                  // already held
        send_frame('0, CLS_DATA, 32'd5, 8'h55);                  // beyond window
        send_frame('0, CLS_DATA, 32'd1, 8'h5A);                  // releases four
        send_frame('0, CLS_DATA, 32'd4, 8'h44);                  // at or below base
        send_frame('0, CLS_DATA, 32'hFFFF_FFFF, 8'h01);
        send_frame('0, CLS_DATA, 32'd0, 8'h02);                  // unsequenced
        send_frame('0, CLS_ACK, 32'd7, 8'h03);
        send_frame('0, CLS_HEARTBEAT, 32'd0, 8'h04);
        // peer still zero: hello takes over even with the link up
        send_frame(32'h1234_5678, CLS_HELLO, 32'd0, 8'h05);
        send_frame(32'hCAFE_F00D, CLS_HELLO, 32'd0, 8'h06);      // link up, refused
        send_event(ACT_FAIL, 1'b0, '0, CLS_DATA, '0, 8'h00);
        send_frame(32'hFFFF_FFFF, CLS_HELLO, 32'd9, 8'h07);      // link down, accepted
        send_frame(32'hFFFF_FFFF, CLS_DATA, 32'd4, 8'hC4);
        send_frame(32'hFFFF_FFFF, CLS_DATA, 32'd1, 8'hC1);
        send_event(ACT_TICK, 1'b1, '1, CLS_HELLO, '1, 8'hFF);
    endtask

    task automatic test_link_timeout();
        set_timeout(16'd1);
        send_event(ACT_TICK, 1'b0, '0, CLS_DATA, '0, 8'h00);     // expires here
        send_event(ACT_TICK, 1'b0, '0, CLS_DATA, '0, 8'h00);     // link already down
        send_event(ACT_TICK, 1'b0, '0, CLS_DATA, '0, 8'h00);
        send_frame('0, CLS_HELLO, 32'd0, 8'h00);
        set_timeout(16'hFFFF);
        send_event(ACT_TICK, 1'b0, '0, CLS_DATA, '0, 8'h00);
    endtask

    task automatic test_random_traffic();
        logic [TIMEOUT_W-1:0] phase_timeout [5];
        logic [SEQ_W-1:0]     seq;
        logic [SESS_W-1:0]    sess;
        int                   pick;
        phase_timeout = '{16'd2, 16'hFFFF, 16'd1, 16'd9, 16'd40};
        for (int p = 0; p < 5; p++) begin
            set_timeout(phase_timeout[p]);
            idle_on <= (p != 2);
            repeat (51) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    case ($urandom_range(0, 9))
                        8:       seq = (win_base != '0) ? $urandom_range(0, win_base) : '0;
                        9:       seq = $urandom;
                        default: seq = win_base + $urandom_range(1, WINDOW + 1);
                    endcase
                    send_frame(peer_id, CLS_DATA, seq, 8'($urandom_range(0, 255)));
                end else if (pick < 62) begin
                    send_event(ACT_TICK, 1'($urandom_range(0, 1)), $urandom,
                               2'($urandom_range(0, 3)), $urandom,
                               8'($urandom_range(0, 255)));
                end else if (pick < 67) begin
                    send_frame(peer_id, 2'($urandom_range(1, 3)),
                               $urandom_range(0, 1) ? '0 : $urandom,
                               8'($urandom_range(0, 255)));
                end else if (pick < 70) begin
                    send_event(ACT_FAIL, 1'($urandom_range(0, 1)), $urandom,
                               2'($urandom_range(0, 3)), $urandom,
                               8'($urandom_range(0, 255)));
                end else if (pick < 76) begin
                    sess = ($urandom_range(0, 7) == 0) ? '0 : $urandom;
                    send_frame(sess, CLS_HELLO, $urandom, 8'($urandom_range(0, 255)));
                end else if (pick < 81) begin
                    send_frame($urandom, CLS_DATA, win_base + $urandom_range(1, WINDOW),
                               8'($urandom_range(0, 255)));
                end else if (pick < 86) begin
                    send_event(ACT_FRAME, 1'b0, $urandom, 2'($urandom_range(0, 3)),
                               $urandom, 8'($urandom_range(0, 255)));
                end else if (pick < 89) begin
                    send_event(ACT_UNUSED, 1'($urandom_range(0, 1)), $urandom,
                               2'($urandom_range(0, 3)), $urandom,
                               8'($urandom_range(0, 255)));
                end else begin
                    send_event(ACT_FRAME, 1'($urandom_range(0, 1)), $urandom,
                               2'($urandom_range(0, 3)), $urandom,
                               8'($urandom_range(0, 255)));
                end
            end
        end
        idle_on <= 1'b1;
    endtask

    initial begin
        fault_count = 0;
        sink_hold   = 0;
        reset_window_model();
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= '0;
        i_m_axis_tready <= 1'b0;
        idle_on         <= 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_window_basics();
        test_link_timeout();
        test_random_traffic();

        wait_quiet();
        repeat (20) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("arq_receive_reorder_window verification clean");
        end else begin
            $display("arq_receive_reorder_window verification failed");
        end
        $finish;
    end

endmodule

>>> arq_receive_reorder_window.f
rtl/core/arw_pkg.sv
rtl/core/arw_front.sv
rtl/core/arw_queue.sv
rtl/core/arw_back.sv
rtl/core/arq_receive_reorder_window.sv
tb/testbench.sv
